// ===== rtl/qfrm_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion core.
package qfrm_pkg;

  // Entry and component width, magnitude width of a paired sum or difference
  localparam int DW    = 16;
  localparam int EW    = 17;
  // Quotient bits kept by the dividers; larger quotients saturate
  localparam int QB    = 17;
  localparam int LANES = 3;

  // Quaternion component slots
  typedef enum logic [1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_Z = 2'd2,
    SLOT_W = 2'd3
  } slot_e;

  // Nine matrix entries, index r*3+c
  typedef logic [8:0][DW-1:0] mat_t;

  // Per-lane magnitudes and quotients
  typedef logic [LANES-1:0][EW-1:0] lanes_t;

  // Control that travels with each transaction
  typedef struct packed {
    slot_e             hsel;
    logic [LANES-1:0]  sgn;
    logic              degen;
  } side_t;

  // Finished result
  typedef struct packed {
    logic [3:0][DW-1:0] comp;
    logic               degen;
  } quat_t;

endpackage

// ===== rtl/qfrm_if.sv =====
// Handshake interfaces for the matrix input and the quaternion output.
interface qfrm_mat_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] m_00;
  logic signed [15:0] m_01;
  logic signed [15:0] m_02;
  logic signed [15:0] m_10;
  logic signed [15:0] m_11;
  logic signed [15:0] m_12;
  logic signed [15:0] m_20;
  logic signed [15:0] m_21;
  logic signed [15:0] m_22;

  modport source (output valid, m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
                  input ready);
  modport sink   (input valid, m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
                  output ready);
endinterface

interface qfrm_quat_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic        degenerate;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, degenerate, output ready);
endinterface

// ===== rtl/qfrm_front.sv =====
// Front stage: trace, branch and axis select, radicand and paired sums.
module qfrm_front #(
  parameter int FRAC_BITS = 14,
  parameter int RADW      = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  qfrm_pkg::mat_t      mat_i,
  output logic                valid_o,
  output logic [RADW-1:0]     rad_o,
  output qfrm_pkg::lanes_t    mags_o,
  output qfrm_pkg::side_t     side_o
);
  localparam int VSW = RADW + 2;

  logic signed [15:0]    m [9];
  logic signed [17:0]    tr;
  logic                  pos;
  logic [1:0]            isel;
  logic signed [15:0]    di, dj, dk;
  logic signed [VSW-1:0] one_c, v, trp;
  logic [RADW-1:0]       rad_d;
  logic                  degen_d;
  logic signed [16:0]    e_s [4];
  qfrm_pkg::slot_e       hsel;
  qfrm_pkg::lanes_t      mags_d;
  logic [2:0]            sgn_d;

  logic                  valid_q;
  logic [RADW-1:0]       rad_q;
  qfrm_pkg::lanes_t      mags_q;
  qfrm_pkg::side_t       side_q;

  function automatic logic signed [16:0] pair(input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic sub);
    pair = sub ? (17'(a) - 17'(b)) : (17'(a) + 17'(b));
  endfunction

  // Unpack entries
  always_comb begin
    for (int n = 0; n < 9; n++) begin
      m[n] = mat_i[n];
    end
  end

  // Trace and largest diagonal entry, ties to the lower index
  assign tr  = 18'(m[0]) + 18'(m[4]) + 18'(m[8]);
  assign pos = tr > 0;

  always_comb begin
    isel = 2'd0;
    if (m[4] > m[0]) isel = 2'd1;
    if (m[8] > ((isel == 2'd1) ? m[4] : m[0])) isel = 2'd2;
  end

  always_comb begin
    case (isel)
      2'd1:    begin di = m[4]; dj = m[8]; dk = m[0]; end
      2'd2:    begin di = m[8]; dj = m[0]; dk = m[4]; end
      default: begin di = m[0]; dj = m[4]; dk = m[8]; end
    endcase
  end

  // Radicand; a non-positive one in the diagonal branch is degenerate
  assign one_c = VSW'(1) << FRAC_BITS;
  assign v     = VSW'(di) - VSW'(dj) - VSW'(dk) + one_c;
  assign trp   = VSW'(tr) + one_c;

  always_comb begin
    degen_d = 1'b0;
    if (pos) begin
      rad_d = trp[RADW-1:0];
    end else if (v > 0) begin
      rad_d = v[RADW-1:0];
    end else begin
      rad_d   = '0;
      degen_d = 1'b1;
    end
  end

  // Paired sums and differences by component slot
  always_comb begin
    e_s[0] = '0; e_s[1] = '0; e_s[2] = '0; e_s[3] = '0;
    hsel   = qfrm_pkg::SLOT_W;
    if (pos) begin
      e_s[qfrm_pkg::SLOT_X] = pair(m[5], m[7], 1'b1);
      e_s[qfrm_pkg::SLOT_Y] = pair(m[6], m[2], 1'b1);
      e_s[qfrm_pkg::SLOT_Z] = pair(m[1], m[3], 1'b1);
    end else begin
      case (isel)
        2'd1: begin
          hsel = qfrm_pkg::SLOT_Y;
          e_s[qfrm_pkg::SLOT_W] = pair(m[6], m[2], 1'b1);
          e_s[qfrm_pkg::SLOT_Z] = pair(m[5], m[7], 1'b0);
          e_s[qfrm_pkg::SLOT_X] = pair(m[3], m[1], 1'b0);
        end
        2'd2: begin
          hsel = qfrm_pkg::SLOT_Z;
          e_s[qfrm_pkg::SLOT_W] = pair(m[1], m[3], 1'b1);
          e_s[qfrm_pkg::SLOT_X] = pair(m[6], m[2], 1'b0);
          e_s[qfrm_pkg::SLOT_Y] = pair(m[7], m[5], 1'b0);
        end
        default: begin
          hsel = qfrm_pkg::SLOT_X;
          e_s[qfrm_pkg::SLOT_W] = pair(m[5], m[7], 1'b1);
          e_s[qfrm_pkg::SLOT_Y] = pair(m[1], m[3], 1'b0);
          e_s[qfrm_pkg::SLOT_Z] = pair(m[2], m[6], 1'b0);
        end
      endcase
    end
  end

  // Lanes carry the three slots other than the half-root slot, in order
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [16:0] e;
      e         = (2'(l) >= hsel) ? e_s[l + 1] : e_s[l];
      sgn_d[l]  = e[16];
      mags_d[l] = e[16] ? 17'(-e) : 17'(e);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q        <= rad_d;
      mags_q       <= mags_d;
      side_q.hsel  <= hsel;
      side_q.sgn   <= sgn_d;
      side_q.degen <= degen_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign mags_o  = mags_q;
  assign side_o  = side_q;
endmodule

// ===== rtl/qfrm_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module qfrm_sqrt #(
  parameter int  FRAC_BITS = 14,
  parameter int  RADW      = 18,
  parameter int  SBW       = 8,
  localparam int XW        = RADW + FRAC_BITS,
  localparam int RW        = (XW + 1) / 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RADW-1:0] rad_i,
  input  logic [SBW-1:0]  sb_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SBW-1:0]  sb_o
);
  localparam int SW = 2 * RW;

  logic            v_q    [RW];
  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SW-1:0]   x_q    [RW];
  logic [SBW-1:0]  sb_q   [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic           vin;
    logic [RW:0]    rin;
    logic [RW-1:0]  qin;
    logic [SW-1:0]  xin;
    logic [SBW-1:0] sbin;
    logic [RW+2:0]  acc, trial;
    logic           ge;

    if (s == 0) begin : g_first
      assign vin  = valid_i;
      assign rin  = '0;
      assign qin  = '0;
      assign xin  = SW'({rad_i, FRAC_BITS'(0)});
      assign sbin = sb_i;
    end else begin : g_next
      assign vin  = v_q[s-1];
      assign rin  = rem_q[s-1];
      assign qin  = root_q[s-1];
      assign xin  = x_q[s-1];
      assign sbin = sb_q[s-1];
    end

    // Bring down two radicand bits, try the next root bit
    assign acc   = {rin, xin[SW-1:SW-2]};
    assign trial = {1'b0, qin, 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? (RW+1)'(acc - trial) : (RW+1)'(acc);
        root_q[s] <= {qin[RW-2:0], ge};
        x_q[s]    <= xin << 2;
        sb_q[s]   <= sbin;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];
endmodule

// ===== rtl/qfrm_div.sv =====
// Three-lane pipelined divider: |e| * 2^F / (2r) rounded, one quotient bit per stage.
module qfrm_div #(
  parameter int  FRAC_BITS = 14,
  parameter int  RW        = 16,
  parameter int  SBW       = 8,
  localparam int NW        = qfrm_pkg::EW + FRAC_BITS + 1,
  localparam int CW        = (NW > RW + 1 + qfrm_pkg::QB) ? NW : RW + 1 + qfrm_pkg::QB
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RW-1:0]     root_i,
  input  qfrm_pkg::lanes_t  mags_i,
  input  logic [SBW-1:0]    sb_i,
  output logic              valid_o,
  output qfrm_pkg::lanes_t  quos_o,
  output logic [2:0]        ovf_o,
  output logic [SBW-1:0]    sb_o
);
  localparam int QB = qfrm_pkg::QB;

  // Setup stage: numerator with rounding term, divisor, overflow check
  logic                   p_v_q;
  logic [2:0][CW-1:0]     p_n_q;
  logic [CW-1:0]          p_d_q;
  logic [2:0]             p_ov_q;
  logic [SBW-1:0]         p_sb_q;
  logic [2:0][CW-1:0]     n_d;
  logic [CW-1:0]          d_d;
  logic [2:0]             ov_d;

  assign d_d = CW'({root_i, 1'b0});

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_d[l]  = CW'({mags_i[l], FRAC_BITS'(0)}) + CW'(root_i);
      ov_d[l] = n_d[l] >= (d_d << QB);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en_i) begin
      p_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_n_q  <= n_d;
      p_d_q  <= d_d;
      p_ov_q <= ov_d;
      p_sb_q <= sb_i;
    end
  end

  // Restoring division stages, most significant quotient bit first
  logic                 v_q   [QB];
  logic [2:0][CW-1:0]   rem_q [QB];
  logic [2:0][QB-1:0]   q_q   [QB];
  logic [CW-1:0]        d_q   [QB];
  logic [2:0]           ov_q  [QB];
  logic [SBW-1:0]       sb_q  [QB];

  for (genvar t = 0; t < QB; t++) begin : g_bit
    localparam int B = QB - 1 - t;
    logic               vin;
    logic [2:0][CW-1:0] rin;
    logic [2:0][QB-1:0] qin;
    logic [CW-1:0]      din;
    logic [2:0]         ovin;
    logic [SBW-1:0]     sbin;
    logic [CW-1:0]      dsh;
    logic [2:0][CW-1:0] rout;
    logic [2:0][QB-1:0] qout;

    if (t == 0) begin : g_first
      assign vin  = p_v_q;
      assign rin  = p_n_q;
      assign qin  = '0;
      assign din  = p_d_q;
      assign ovin = p_ov_q;
      assign sbin = p_sb_q;
    end else begin : g_next
      assign vin  = v_q[t-1];
      assign rin  = rem_q[t-1];
      assign qin  = q_q[t-1];
      assign din  = d_q[t-1];
      assign ovin = ov_q[t-1];
      assign sbin = sb_q[t-1];
    end

    assign dsh = din << B;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rin[l] >= dsh) begin
          rout[l] = rin[l] - dsh;
          qout[l] = {qin[l][QB-2:0], 1'b1};
        end else begin
          rout[l] = rin[l];
          qout[l] = {qin[l][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[t] <= 1'b0;
      end else if (en_i) begin
        v_q[t] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[t] <= rout;
        q_q[t]   <= qout;
        d_q[t]   <= din;
        ov_q[t]  <= ovin;
        sb_q[t]  <= sbin;
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign quos_o  = q_q[QB-1];
  assign ovf_o   = ov_q[QB-1];
  assign sb_o    = sb_q[QB-1];
endmodule

// ===== rtl/quaternion_from_rotation_matrix_core.sv =====
// RW = (FRAC_BITS + max(FRAC_BITS,17) + 2) / 2, which is 16 at FRAC_BITS = 14.
// The pipeline is one front stage, RW square root stages, 18 divider stages and one output stage.
// Throughput: one transaction per cycle while the skid buffer is empty; the root and divider pipelines set the depth.
// A one-entry skid buffer holds a result while the output stalls; the pipeline then freezes.
// Reset (rst_ni low, asynchronous) clears all valid bits, including the skid buffer's.
module quaternion_from_rotation_matrix_core #(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qfrm_mat_if.sink    mat_i,
  qfrm_quat_if.source quat_o
);
  localparam int RADW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int RW   = (RADW + FRAC_BITS + 1) / 2;
  localparam int SB1  = $bits(qfrm_pkg::side_t) + qfrm_pkg::LANES * qfrm_pkg::EW;
  localparam int SB2  = $bits(qfrm_pkg::side_t) + RW;
  localparam int HW   = RW - 1;
  localparam int HXW  = (HW > 16) ? HW : 16;

  logic              en;
  qfrm_pkg::mat_t    mat;

  logic              f_v;
  logic [RADW-1:0]   f_rad;
  qfrm_pkg::lanes_t  f_mags;
  qfrm_pkg::side_t   f_side;

  logic              s_v;
  logic [RW-1:0]     s_root;
  logic [SB1-1:0]    s_sb;
  qfrm_pkg::side_t   s_side;
  qfrm_pkg::lanes_t  s_mags;

  logic              d_v;
  qfrm_pkg::lanes_t  d_quos;
  logic [2:0]        d_ovf;
  logic [SB2-1:0]    d_sb;
  qfrm_pkg::side_t   d_side;
  logic [RW-1:0]     d_root;

  logic [HXW-1:0]    hx;
  logic [15:0]       hsat;
  logic [2:0][15:0]  lane_val;
  qfrm_pkg::quat_t   fin_d, fin_q, skid_q, out_sel;
  logic              fin_v_q, skid_v_q;

  // Pipeline advances unless the skid buffer is holding a result
  assign en          = !skid_v_q;
  assign mat_i.ready = en;

  assign mat = {mat_i.m_22, mat_i.m_21, mat_i.m_20,
                mat_i.m_12, mat_i.m_11, mat_i.m_10,
                mat_i.m_02, mat_i.m_01, mat_i.m_00};

  qfrm_front #(.FRAC_BITS(FRAC_BITS), .RADW(RADW)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(mat_i.valid), .mat_i(mat),
    .valid_o(f_v), .rad_o(f_rad), .mags_o(f_mags), .side_o(f_side)
  );

  qfrm_sqrt #(.FRAC_BITS(FRAC_BITS), .RADW(RADW), .SBW(SB1)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_v), .rad_i(f_rad),
    .sb_i({f_side, f_mags}),
    .valid_o(s_v), .root_o(s_root), .sb_o(s_sb)
  );

  assign {s_side, s_mags} = s_sb;

  qfrm_div #(.FRAC_BITS(FRAC_BITS), .RW(RW), .SBW(SB2)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_v), .root_i(s_root), .mags_i(s_mags),
    .sb_i({s_side, s_root}),
    .valid_o(d_v), .quos_o(d_quos), .ovf_o(d_ovf), .sb_o(d_sb)
  );

  assign {d_side, d_root} = d_sb;

  // Half-root component, saturated
  assign hx   = HXW'(d_root >> 1);
  assign hsat = (hx > HXW'(32767)) ? 16'h7fff : hx[15:0];

  // Signed, saturated lane results
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic big;
      big = d_ovf[l] | d_quos[l][16] | d_quos[l][15];
      if (d_side.sgn[l]) begin
        lane_val[l] = big ? 16'h8000 : 16'(-d_quos[l][15:0]);
      end else begin
        lane_val[l] = big ? 16'h7fff : d_quos[l][15:0];
      end
    end
  end

  // Route lanes back to component slots
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (d_side.degen) begin
        fin_d.comp[c] = '0;
      end else if (2'(c) == d_side.hsel) begin
        fin_d.comp[c] = hsat;
      end else if (2'(c) > d_side.hsel) begin
        fin_d.comp[c] = lane_val[c-1];
      end else begin
        fin_d.comp[c] = lane_val[c];
      end
    end
    fin_d.degen = d_side.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        fin_v_q <= d_v;
      end
      if (skid_v_q) begin
        skid_v_q <= !quat_o.ready;
      end else begin
        skid_v_q <= fin_v_q && !quat_o.ready;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
    if (!skid_v_q) begin
      skid_q <= fin_q;
    end
  end

  // Output from skid buffer first
  assign out_sel           = skid_v_q ? skid_q : fin_q;
  assign quat_o.valid      = skid_v_q | fin_v_q;
  assign quat_o.quat_x     = out_sel.comp[qfrm_pkg::SLOT_X];
  assign quat_o.quat_y     = out_sel.comp[qfrm_pkg::SLOT_Y];
  assign quat_o.quat_z     = out_sel.comp[qfrm_pkg::SLOT_Z];
  assign quat_o.quat_w     = out_sel.comp[qfrm_pkg::SLOT_W];
  assign quat_o.degenerate = out_sel.degen;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quat_o.valid && quat_o.degenerate |->
      quat_o.quat_x == 0 && quat_o.quat_y == 0 && quat_o.quat_z == 0 && quat_o.quat_w == 0)
    else $error("degenerate result with nonzero component");

  a_skid_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> quat_o.valid && !mat_i.ready)
    else $error("skid buffer full but input still ready");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && fin_v_q |=> fin_v_q && $stable(fin_q))
    else $error("output stage changed while pipeline frozen");
`endif
endmodule

// ===== tb/sv/quaternion_from_rotation_matrix_core_tb.sv =====
// Testbench for the rotation matrix to quaternion core: directed and random matrices.
module quaternion_from_rotation_matrix_core_tb;

  localparam int FB       = 14;
  localparam int ONE      = 1 << FB;
  localparam int LATENCY  = 36;
  localparam longint LIMIT = 400000;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [15:0] q [4];
    logic               degen;
  } quat_exp_t;

  logic clk_i;
  logic rst_ni;

  qfrm_mat_if  mat_bus ();
  qfrm_quat_if quat_bus ();

  quaternion_from_rotation_matrix_core #(.FRAC_BITS(FB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mat_i  (mat_bus.sink),
    .quat_o (quat_bus.source)
  );

  quat_exp_t   pending_quats [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;
  longint      cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("FAIL quaternion_from_rotation_matrix_core");
        $finish;
      end
    end
  end

  // Integer square root, truncated
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // e * 2^F / (2r), rounded half away from zero
  function automatic logic signed [15:0] div_by_root(longint e, longint unsigned r);
    longint unsigned mag;
    longint unsigned quo;
    if (r == 0) return '0;
    mag = (e < 0) ? -e : e;
    quo = ((mag << FB) + r) / (2 * r);
    if (quo > 65536) quo = 65536;
    return clamp16((e < 0) ? -longint'(quo) : longint'(quo));
  endfunction

  function automatic logic signed [15:0] half_of_root(longint unsigned r);
    longint unsigned h;
    h = r >> 1;
    if (h > 32767) h = 32767;
    return h[15:0];
  endfunction

  function automatic quat_exp_t predict_quat(matrix_t mx);
    quat_exp_t res;
    longint e [3][3];
    longint tr;
    longint v;
    longint unsigned r;
    int i, j, k;
    for (int a = 0; a < 9; a++) e[a / 3][a % 3] = mx.m[a];
    for (int a = 0; a < 4; a++) res.q[a] = '0;
    res.degen = 1'b0;
    tr = e[0][0] + e[1][1] + e[2][2];
    if (tr > 0) begin
      r = int_sqrt(longint'(tr + ONE) << FB);
      res.q[qfrm_pkg::SLOT_W] = half_of_root(r);
      res.q[qfrm_pkg::SLOT_X] = div_by_root(e[1][2] - e[2][1], r);
      res.q[qfrm_pkg::SLOT_Y] = div_by_root(e[2][0] - e[0][2], r);
      res.q[qfrm_pkg::SLOT_Z] = div_by_root(e[0][1] - e[1][0], r);
    end else begin
      i = 0;
      if (e[1][1] > e[0][0]) i = 1;
      if (e[2][2] > e[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      v = e[i][i] - (e[j][j] + e[k][k]) + ONE;
      if (v > 0) begin
        r = int_sqrt(longint'(v) << FB);
        res.q[i]                = half_of_root(r);
        res.q[qfrm_pkg::SLOT_W] = div_by_root(e[j][k] - e[k][j], r);
        res.q[j]                = div_by_root(e[i][j] + e[j][i], r);
        res.q[k]                = div_by_root(e[i][k] + e[k][i], r);
      end else begin
        res.degen = 1'b1;
      end
    end
    return res;
  endfunction

  // Receiver: random ready, long hold-off on request
  initial begin
    quat_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) quat_bus.ready <= 1'b0;
      else quat_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  initial begin
    quat_exp_t exp_q;
    logic signed [15:0] got [4];
    forever begin
      @(posedge clk_i);
      if (rst_ni && quat_bus.valid && quat_bus.ready) begin
        got[0] = quat_bus.quat_x;
        got[1] = quat_bus.quat_y;
        got[2] = quat_bus.quat_z;
        got[3] = quat_bus.quat_w;
        if (pending_quats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected quaternion transaction");
        end else begin
          exp_q = pending_quats.pop_front();
          if (got != exp_q.q || quat_bus.degenerate !== exp_q.degen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%0d y=%0d z=%0d w=%0d d=%0b got %0d %0d %0d %0d %0b",
                       exp_q.q[0], exp_q.q[1], exp_q.q[2], exp_q.q[3], exp_q.degen,
                       got[0], got[1], got[2], got[3], quat_bus.degenerate);
          end
        end
      end
    end
  end

  // Send one matrix transaction; valid stays up for a following one
  task automatic send_matrix(matrix_t mx);
    while ($urandom_range(99) < send_idle_pct) begin
      mat_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    mat_bus.valid <= 1'b1;
    mat_bus.m_00 <= mx.m[0];
    mat_bus.m_01 <= mx.m[1];
    mat_bus.m_02 <= mx.m[2];
    mat_bus.m_10 <= mx.m[3];
    mat_bus.m_11 <= mx.m[4];
    mat_bus.m_12 <= mx.m[5];
    mat_bus.m_20 <= mx.m[6];
    mat_bus.m_21 <= mx.m[7];
    mat_bus.m_22 <= mx.m[8];
    do @(posedge clk_i); while (!mat_bus.ready);
    pending_quats.push_back(predict_quat(mx));
    @(negedge clk_i);
  endtask

  // Stop offering, then wait for every expected result
  task automatic drain_results();
    mat_bus.valid <= 1'b0;
    while (pending_quats.size() != 0) @(negedge clk_i);
  endtask

  function automatic matrix_t diag_matrix(int a, int b, int c);
    matrix_t mx;
    for (int n = 0; n < 9; n++) mx.m[n] = '0;
    mx.m[0] = 16'(a);
    mx.m[4] = 16'(b);
    mx.m[8] = 16'(c);
    return mx;
  endfunction

  // Rotation-like matrix: each branch, perturbations of up to 800 or 16000
  function automatic matrix_t rotation_like();
    matrix_t mx;
    int s;
    mx = diag_matrix(0, 0, 0);
    case ($urandom_range(3))
      0: mx = diag_matrix(ONE, ONE, ONE);
      1: mx = diag_matrix(ONE, -ONE, -ONE);
      2: mx = diag_matrix(-ONE, ONE, -ONE);
      default: mx = diag_matrix(-ONE, -ONE, ONE);
    endcase
    s = $urandom_range(2) == 0 ? 16000 : 800;
    for (int n = 0; n < 9; n++)
      mx.m[n] = clamp16(longint'(mx.m[n]) + $urandom_range(2 * s) - s);
    return mx;
  endfunction

  function automatic matrix_t noise_matrix();
    matrix_t mx;
    for (int n = 0; n < 9; n++) mx.m[n] = 16'($urandom);
    return mx;
  endfunction

  task automatic test_directed();
    matrix_t mx;
    send_matrix(diag_matrix(ONE, ONE, ONE));
    send_matrix(diag_matrix(ONE, -ONE, -ONE));
    send_matrix(diag_matrix(-ONE, ONE, -ONE));
    send_matrix(diag_matrix(-ONE, -ONE, ONE));
    send_matrix(diag_matrix(0, 0, 0));           // zero trace, ties to lowest
    send_matrix(diag_matrix(-ONE, -ONE, -ONE));  // ties, radicand positive
    send_matrix(diag_matrix(-32768, 0, 0));      // tie on zeros
    send_matrix(diag_matrix(0, 32767, 32767));   // positive trace despite a tie on 1,2
    send_matrix(diag_matrix(-16384, 32767, 32767)); // big positive trace
    send_matrix(diag_matrix(-32768, -32768, -32768));
    send_matrix(diag_matrix(1, 0, 0));           // tiny trace, huge scale
    mx = diag_matrix(1, 0, 0);
    for (int n = 0; n < 9; n++) if (n % 4 != 0) mx.m[n] = (n % 2) ? 16'sd32767 : -16'sd32768;
    send_matrix(mx);                             // symmetric off-diagonal entries, zero pair differences
    mx = diag_matrix(-32768, -32768, 32767);
    for (int n = 0; n < 9; n++) if (n % 4 != 0) mx.m[n] = (n % 2) ? -16'sd32768 : 16'sd32767;
    send_matrix(mx);
    mx = diag_matrix(-ONE, 0, -ONE);
    mx.m[1] = 16'sd32767; mx.m[3] = 16'sd32767;
    send_matrix(mx);
    for (int n = 0; n < 4; n++) send_matrix(noise_matrix());
    drain_results();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++)
      send_matrix(($urandom_range(99) < 75) ? rotation_like() : noise_matrix());
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (150) @(negedge clk_i);
        hold_off = 1'b0;
      end
      test_random(80);
    join
    drain_results();
    test_random(10);
  endtask

  initial begin
    mismatches = 0;
    hold_off = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 54;
    mat_bus.valid = 1'b0;
    mat_bus.m_00 = '0; mat_bus.m_01 = '0; mat_bus.m_02 = '0;
    mat_bus.m_10 = '0; mat_bus.m_11 = '0; mat_bus.m_12 = '0;
    mat_bus.m_20 = '0; mat_bus.m_21 = '0; mat_bus.m_22 = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(200);
    send_idle_pct = 54;
    recv_idle_pct = 28;
    test_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(200);

    drain_results();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatches == 0 && pending_quats.size() == 0) begin
      $display("PASS quaternion_from_rotation_matrix_core");
    end else begin
      $display("FAIL quaternion_from_rotation_matrix_core");
    end
    $finish;
  end

endmodule
